@@ hw/rtl/tef_pkg.sv @@
// Shared types, codes and constants for the tetrahedron elastic force block.
`timescale 1ns / 1ps
package tef_pkg;

  localparam int VALUE_BITS = 32;
  localparam int OPA_BITS   = 34;
  localparam int PROD_BITS  = OPA_BITS + VALUE_BITS;
  localparam int FORCE_BITS = 64;
  localparam int ADDR_BITS  = 4;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  localparam val_t Q_ONE     = val_t'(32'sd65536);
  localparam val_t Q_NEG_ONE = val_t'(-32'sd65536);

  // configuration register indexes
  localparam logic [1:0] REG_LAMBDA = 2'd0;
  localparam logic [1:0] REG_MU     = 2'd1;
  localparam logic [1:0] REG_PHI    = 2'd2;
  localparam logic [1:0] REG_PSI    = 2'd3;

  localparam logic [1:0] LAST_SLOT = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE, PH_F, PH_FD, PH_EPS, PH_NU, PH_TR, PH_SIG,
    PH_G, PH_MAG, PH_SUM, PH_FRC, PH_EMIT
  } phase_e;

  typedef enum logic [3:0] {
    SA_BAS, SA_FA, SA_ONE, SA_NEG1, SA_LAMBDA, SA_MU2, SA_PHI, SA_PSI2,
    SA_MAG, SA_VOL
  } src_a_e;

  typedef enum logic [3:0] {
    SB_POS, SB_VEL, SB_FB, SB_FD, SB_EPS, SB_NU, SB_ETR, SB_NTR,
    SB_SIG, SB_G, SB_SUM, SB_ONE
  } src_b_e;

  // Q16: Q16.16 product, INT: whole-unit product, FRC: halved and negated force
  typedef enum logic [1:0] {MODE_Q16, MODE_INT, MODE_FRC} mode_e;

  typedef enum logic [3:0] {
    DST_F, DST_FD, DST_EPS, DST_NU, DST_ETR, DST_NTR, DST_SIG,
    DST_G, DST_MAG, DST_SUM, DST_FRES
  } dst_e;

  typedef struct packed {
    logic       valid;
    src_a_e     a_sel;
    logic [1:0] a_row;
    logic [1:0] a_col;
    src_b_e     b_sel;
    logic [1:0] b_row;
    logic [1:0] b_col;
    mode_e      mode;
    logic       first;
    logic       last;
    dst_e       dst;
    logic [1:0] d_row;
    logic [1:0] d_col;
  } op_t;

  typedef struct packed {
    logic                  valid;
    dst_e                  dst;
    logic [1:0]            d_row;
    logic [1:0]            d_col;
    logic [FORCE_BITS-1:0] value;
  } wr_t;

endpackage

@@ hw/rtl/tet_elastic_force_top.sv @@
// Top level: vertex stores, work registers, register port and result channel.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    vertex_slot_i .. rest_volume_i
//   out      output     out_valid_o / out_stall_i  node_slot_o .. last_node_o
//   config   input      psel/penable/pwrite        paddr, pwdata, prdata
//
// Slot 0..2 items are stored on acceptance. A slot 3 item starts the work, one
// multiply issued per cycle on the shared 34x32 multiplier except in the bubble
// after each phase or while a result waits (two gradient passes, strain, strain
// rate, traces, stress, then a pass per node). Each node waits while out_stall_i
// holds the previous result. Reset clears control state and configuration only.
`timescale 1ns / 1ps
module tet_elastic_force_top import tef_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            vertex_slot_i,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic signed [31:0]    pos_z_i,
  input  logic signed [31:0]    vel_x_i,
  input  logic signed [31:0]    vel_y_i,
  input  logic signed [31:0]    vel_z_i,
  input  logic signed [31:0]    basis_c0_i,
  input  logic signed [31:0]    basis_c1_i,
  input  logic signed [31:0]    basis_c2_i,
  input  logic signed [31:0]    basis_c3_i,
  input  logic [30:0]           rest_volume_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            node_slot_o,
  output logic signed [63:0]    force_x_o,
  output logic signed [63:0]    force_y_o,
  output logic signed [63:0]    force_z_o,
  output logic                  last_node_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0] lambda_q, mu_q, phi_q, psi_q;
  logic [30:0] vol_q;

  val_t pos_q [4][3];
  val_t vel_q [4][3];
  val_t bas_q [4][4];
  val_t fa_q  [3][3];
  val_t fb_q  [3][3];
  val_t fd_q  [3][3];
  val_t eps_q [3][3];
  val_t nu_q  [3][3];
  val_t sig_q [3][3];
  val_t g_q   [3];
  val_t mag_q [4];
  val_t sum_q [3];
  val_t etr_q, ntr_q;
  logic [FORCE_BITS-1:0] fres_q [3];

  logic out_valid_q, last_q;
  logic [1:0] node_slot_q;
  logic [FORCE_BITS-1:0] fx_q, fy_q, fz_q;

  logic in_acc, out_acc, cfg_wr, busy, emit, emit_ok;
  logic [1:0] node;
  op_t  op;
  wr_t  wr;
  logic signed [OPA_BITS-1:0] a_val;
  val_t b_val;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign emit_ok = !out_valid_q || !out_stall_i;

  tef_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc && vertex_slot_i == LAST_SLOT),
    .emit_ok_i (emit_ok),
    .op_o      (op),
    .busy_o    (busy),
    .emit_o    (emit),
    .node_o    (node)
  );

  tef_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .a_i    (a_val),
    .b_i    (b_val),
    .wr_o   (wr)
  );

  assign in_stall_o = busy;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= '0;
      mu_q     <= '0;
      phi_q    <= '0;
      psi_q    <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LAMBDA: lambda_q <= pwdata;
        REG_MU:     mu_q     <= pwdata;
        REG_PHI:    phi_q    <= pwdata;
        REG_PSI:    psi_q    <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LAMBDA: prdata = lambda_q;
      REG_MU:     prdata = mu_q;
      REG_PHI:    prdata = phi_q;
      REG_PSI:    prdata = psi_q;
      default:    prdata = '0;
    endcase
  end

  // operand selection
  always_comb begin
    case (op.a_sel)
      SA_BAS: begin
        a_val = OPA_BITS'(bas_q[op.a_row][op.a_col]);
      end
      SA_FA:     a_val = OPA_BITS'(fa_q[op.a_row][op.a_col]);
      SA_ONE:    a_val = OPA_BITS'(Q_ONE);
      SA_NEG1:   a_val = OPA_BITS'(Q_NEG_ONE);
      SA_LAMBDA: a_val = {2'b00, lambda_q};
      SA_MU2:    a_val = {1'b0, mu_q, 1'b0};
      SA_PHI:    a_val = {2'b00, phi_q};
      SA_PSI2:   a_val = {1'b0, psi_q, 1'b0};
      SA_MAG:    a_val = OPA_BITS'(mag_q[op.a_row]);
      SA_VOL:    a_val = {3'b000, vol_q};
      default:   a_val = '0;
    endcase
    case (op.b_sel)
      SB_POS:  b_val = pos_q[op.b_row][op.b_col];
      SB_VEL:  b_val = vel_q[op.b_row][op.b_col];
      SB_FB:   b_val = fb_q[op.b_row][op.b_col];
      SB_FD:   b_val = fd_q[op.b_row][op.b_col];
      SB_EPS:  b_val = eps_q[op.b_row][op.b_col];
      SB_NU:   b_val = nu_q[op.b_row][op.b_col];
      SB_ETR:  b_val = etr_q;
      SB_NTR:  b_val = ntr_q;
      SB_SIG:  b_val = sig_q[op.b_row][op.b_col];
      SB_G:    b_val = g_q[op.b_row];
      SB_SUM:  b_val = sum_q[op.b_row];
      SB_ONE:  b_val = Q_ONE;
      default: b_val = '0;
    endcase
  end

  // vertex stores and result write-back
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q[vertex_slot_i][0] <= pos_x_i;
      pos_q[vertex_slot_i][1] <= pos_y_i;
      pos_q[vertex_slot_i][2] <= pos_z_i;
      vel_q[vertex_slot_i][0] <= vel_x_i;
      vel_q[vertex_slot_i][1] <= vel_y_i;
      vel_q[vertex_slot_i][2] <= vel_z_i;
      bas_q[vertex_slot_i][0] <= basis_c0_i;
      bas_q[vertex_slot_i][1] <= basis_c1_i;
      bas_q[vertex_slot_i][2] <= basis_c2_i;
      bas_q[vertex_slot_i][3] <= basis_c3_i;
      if (vertex_slot_i == LAST_SLOT) begin
        vol_q <= rest_volume_i;
      end
    end
    if (wr.valid) begin
      case (wr.dst)
        DST_F: begin
          fa_q[wr.d_row][wr.d_col] <= wr.value[VALUE_BITS-1:0];
          fb_q[wr.d_row][wr.d_col] <= wr.value[VALUE_BITS-1:0];
        end
        DST_FD:   fd_q[wr.d_row][wr.d_col]  <= wr.value[VALUE_BITS-1:0];
        DST_EPS:  eps_q[wr.d_row][wr.d_col] <= wr.value[VALUE_BITS-1:0];
        DST_NU:   nu_q[wr.d_row][wr.d_col]  <= wr.value[VALUE_BITS-1:0];
        DST_ETR:  etr_q <= wr.value[VALUE_BITS-1:0];
        DST_NTR:  ntr_q <= wr.value[VALUE_BITS-1:0];
        DST_SIG:  sig_q[wr.d_row][wr.d_col] <= wr.value[VALUE_BITS-1:0];
        DST_G:    g_q[wr.d_row]   <= wr.value[VALUE_BITS-1:0];
        DST_MAG:  mag_q[wr.d_row] <= wr.value[VALUE_BITS-1:0];
        DST_SUM:  sum_q[wr.d_row] <= wr.value[VALUE_BITS-1:0];
        DST_FRES: fres_q[wr.d_row] <= wr.value;
        default:  ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      node_slot_q <= node;
      fx_q        <= fres_q[0];
      fy_q        <= fres_q[1];
      fz_q        <= fres_q[2];
      last_q      <= (node == LAST_SLOT);
    end
  end

  assign out_valid_o = out_valid_q;
  assign node_slot_o = node_slot_q;
  assign force_x_o   = fx_q;
  assign force_y_o   = fy_q;
  assign force_z_o   = fz_q;
  assign last_node_o = last_q;

  a_wb_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.valid |-> busy)
    else $error("write-back while sequencer idle");

  a_start_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && vertex_slot_i == LAST_SLOT) |=> in_stall_o)
    else $error("no stall after last vertex");

  a_last_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_node_o) |-> (node_slot_o == LAST_SLOT))
    else $error("last flag on wrong node");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(emit))
    else $error("result appeared without emit");

endmodule

@@ hw/rtl/tef_mac.sv @@
// Shared multiply, round, saturate and accumulate unit with a product register.
`timescale 1ns / 1ps
module tef_mac import tef_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  op_t                        op_i,
  input  logic signed [OPA_BITS-1:0] a_i,
  input  val_t                       b_i,
  output wr_t                        wr_o
);

  logic                         p_vld_q;
  logic signed [PROD_BITS-1:0]  prod_q;
  mode_e                        mode_q;
  logic                         first_q, last_q;
  dst_e                         dst_q;
  logic [1:0]                   row_q, col_q;
  val_t                         acc_q;

  logic                         neg;
  logic [PROD_BITS-1:0]         pmag, rnd, msat;
  logic [FORCE_BITS-1:0]        lim, res64;
  val_t                         left, res_v, sum_v;
  logic signed [VALUE_BITS:0]   s_wide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= op_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= PROD_BITS'(a_i * $signed({{(OPA_BITS-VALUE_BITS){b_i[VALUE_BITS-1]}}, b_i}));
    mode_q  <= op_i.mode;
    first_q <= op_i.first;
    last_q  <= op_i.last;
    dst_q   <= op_i.dst;
    row_q   <= op_i.d_row;
    col_q   <= op_i.d_col;
    if (p_vld_q) begin
      acc_q <= sum_v;
    end
  end

  // sign-magnitude rounding: magnitude rounded half away from zero
  always_comb begin
    neg  = prod_q[PROD_BITS-1] ^ (mode_q == MODE_FRC);
    pmag = prod_q[PROD_BITS-1] ? PROD_BITS'(-prod_q) : PROD_BITS'(prod_q);
    case (mode_q)
      MODE_Q16: rnd = (pmag + PROD_BITS'(32768)) >> 16;
      MODE_INT: rnd = pmag;
      MODE_FRC: rnd = (pmag + PROD_BITS'(1)) >> 1;
      default:  rnd = pmag;
    endcase
    if (mode_q == MODE_FRC) begin
      lim = {1'b0, {(FORCE_BITS-1){1'b1}}} + FORCE_BITS'(neg);
    end else begin
      lim = FORCE_BITS'({1'b0, {(VALUE_BITS-1){1'b1}}}) + FORCE_BITS'(neg);
    end
    msat  = (rnd > PROD_BITS'(lim)) ? PROD_BITS'(lim) : rnd;
    res64 = neg ? FORCE_BITS'(-msat[FORCE_BITS-1:0]) : msat[FORCE_BITS-1:0];
    res_v = val_t'(res64[VALUE_BITS-1:0]);
    left  = first_q ? '0 : acc_q;
    s_wide = {left[VALUE_BITS-1], left} + {res_v[VALUE_BITS-1], res_v};
    if (s_wide[VALUE_BITS] != s_wide[VALUE_BITS-1]) begin
      sum_v = s_wide[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                 : {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else begin
      sum_v = s_wide[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    wr_o.valid = p_vld_q && last_q;
    wr_o.dst   = dst_q;
    wr_o.d_row = row_q;
    wr_o.d_col = col_q;
    if (mode_q == MODE_FRC) begin
      wr_o.value = res64;
    end else begin
      wr_o.value = {{(FORCE_BITS-VALUE_BITS){sum_v[VALUE_BITS-1]}}, sum_v};
    end
  end

endmodule

@@ hw/rtl/tef_seq.sv @@
// Sequencer issuing one MAC op per cycle except in bubbles and emit.
`timescale 1ns / 1ps
module tef_seq import tef_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       emit_ok_i,
  output op_t        op_o,
  output logic       busy_o,
  output logic       emit_o,
  output logic [1:0] node_o
);

  phase_e     phase_q, phase_d;
  logic       bub_q, bub_d;
  logic [1:0] ga_q, ga_d, gb_q, gb_d, node_q, node_d;
  logic [2:0] tm_q, tm_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bub_q   <= 1'b0;
      ga_q    <= '0;
      gb_q    <= '0;
      tm_q    <= '0;
      node_q  <= '0;
    end else begin
      phase_q <= phase_d;
      bub_q   <= bub_d;
      ga_q    <= ga_d;
      gb_q    <= gb_d;
      tm_q    <= tm_d;
      node_q  <= node_d;
    end
  end

  always_comb begin
    logic       diag, comp;
    logic [1:0] ga_max, gb_max;
    logic [2:0] tm_max, tm3;
    phase_e     nxt;

    diag   = (ga_q == gb_q);
    tm3    = tm_q - 3'd3;
    ga_max = 2'd2;
    gb_max = 2'd0;
    tm_max = 3'd0;
    nxt    = PH_IDLE;
    comp   = 1'b1;
    op_o   = '0;
    op_o.mode  = MODE_Q16;
    op_o.d_row = ga_q;
    op_o.d_col = gb_q;

    case (phase_q)
      PH_F, PH_FD: begin
        gb_max = 2'd2; tm_max = 3'd3;
        nxt = (phase_q == PH_F) ? PH_FD : PH_EPS;
        op_o.a_sel = SA_BAS; op_o.a_row = tm_q[1:0]; op_o.a_col = gb_q;
        op_o.b_sel = (phase_q == PH_F) ? SB_POS : SB_VEL;
        op_o.b_row = tm_q[1:0]; op_o.b_col = ga_q;
        op_o.dst   = (phase_q == PH_F) ? DST_F : DST_FD;
      end
      PH_EPS: begin
        gb_max = 2'd2; tm_max = diag ? 3'd3 : 3'd2; nxt = PH_NU;
        op_o.dst = DST_EPS;
        if (tm_q < 3'd3) begin
          op_o.a_sel = SA_FA; op_o.a_row = tm_q[1:0]; op_o.a_col = ga_q;
          op_o.b_sel = SB_FB; op_o.b_row = tm_q[1:0]; op_o.b_col = gb_q;
        end else begin
          // subtract the identity on the diagonal
          op_o.a_sel = SA_NEG1; op_o.b_sel = SB_ONE;
        end
      end
      PH_NU: begin
        gb_max = 2'd2; tm_max = 3'd5; nxt = PH_TR;
        op_o.dst = DST_NU; op_o.a_sel = SA_FA; op_o.b_sel = SB_FD;
        if (tm_q < 3'd3) begin
          op_o.a_row = tm_q[1:0]; op_o.a_col = ga_q;
          op_o.b_row = tm_q[1:0]; op_o.b_col = gb_q;
        end else begin
          op_o.a_row = tm3[1:0]; op_o.a_col = gb_q;
          op_o.b_row = tm3[1:0]; op_o.b_col = ga_q;
        end
      end
      PH_TR: begin
        ga_max = 2'd1; tm_max = 3'd2; nxt = PH_SIG;
        op_o.a_sel = SA_ONE;
        op_o.b_sel = (ga_q == 2'd0) ? SB_EPS : SB_NU;
        op_o.b_row = tm_q[1:0]; op_o.b_col = tm_q[1:0];
        op_o.dst   = (ga_q == 2'd0) ? DST_ETR : DST_NTR;
      end
      PH_SIG: begin
        gb_max = 2'd2; tm_max = diag ? 3'd3 : 3'd1; nxt = PH_G;
        op_o.mode = MODE_INT; op_o.dst = DST_SIG;
        op_o.b_row = ga_q; op_o.b_col = gb_q;
        case ({diag, tm_q[1:0]})
          3'b100:  begin op_o.a_sel = SA_LAMBDA; op_o.b_sel = SB_ETR; end
          3'b101:  begin op_o.a_sel = SA_MU2;    op_o.b_sel = SB_EPS; end
          3'b110:  begin op_o.a_sel = SA_PHI;    op_o.b_sel = SB_NTR; end
          3'b111:  begin op_o.a_sel = SA_PSI2;   op_o.b_sel = SB_NU;  end
          3'b000:  begin op_o.a_sel = SA_MU2;    op_o.b_sel = SB_EPS; end
          default: begin op_o.a_sel = SA_PSI2;   op_o.b_sel = SB_NU;  end
        endcase
      end
      PH_G: begin
        tm_max = 3'd2; nxt = PH_MAG;
        op_o.a_sel = SA_BAS; op_o.a_row = node_q; op_o.a_col = tm_q[1:0];
        op_o.b_sel = SB_SIG; op_o.b_row = tm_q[1:0]; op_o.b_col = ga_q;
        op_o.dst = DST_G;
      end
      PH_MAG: begin
        ga_max = 2'd3; tm_max = 3'd2; nxt = PH_SUM;
        op_o.a_sel = SA_BAS; op_o.a_row = ga_q; op_o.a_col = tm_q[1:0];
        op_o.b_sel = SB_G; op_o.b_row = tm_q[1:0];
        op_o.dst = DST_MAG;
      end
      PH_SUM: begin
        tm_max = 3'd3; nxt = PH_FRC;
        op_o.a_sel = SA_MAG; op_o.a_row = tm_q[1:0];
        op_o.b_sel = SB_POS; op_o.b_row = tm_q[1:0]; op_o.b_col = ga_q;
        op_o.dst = DST_SUM;
      end
      PH_FRC: begin
        nxt = PH_EMIT; op_o.mode = MODE_FRC;
        op_o.a_sel = SA_VOL; op_o.b_sel = SB_SUM; op_o.b_row = ga_q;
        op_o.dst = DST_FRES;
      end
      default: comp = 1'b0;
    endcase

    op_o.valid = comp && !bub_q;
    op_o.first = (tm_q == 3'd0);
    op_o.last  = (tm_q == tm_max);

    phase_d = phase_q;
    bub_d   = 1'b0;
    ga_d    = ga_q;
    gb_d    = gb_q;
    tm_d    = tm_q;
    node_d  = node_q;
    emit_o  = 1'b0;
    busy_o  = (phase_q != PH_IDLE);

    if (op_o.valid) begin
      if (op_o.last) begin
        tm_d = '0;
        if (gb_q == gb_max) begin
          gb_d = '0;
          ga_d = ga_q + 2'd1;
        end else begin
          gb_d = gb_q + 2'd1;
        end
        // insert a bubble so the next phase reads the written result
        if (ga_q == ga_max && gb_q == gb_max) begin
          ga_d    = '0;
          phase_d = nxt;
          bub_d   = 1'b1;
        end
      end else begin
        tm_d = tm_q + 3'd1;
      end
    end

    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_F;
          node_d  = '0;
          ga_d    = '0;
          gb_d    = '0;
          tm_d    = '0;
        end
      end
      PH_EMIT: begin
        // wait for the last force component to be written back
        if (emit_ok_i && !bub_q) begin
          emit_o = 1'b1;
          if (node_q == LAST_SLOT) begin
            phase_d = PH_IDLE;
          end else begin
            node_d  = node_q + 2'd1;
            phase_d = PH_G;
          end
        end
      end
      default: ;
    endcase
  end

  assign node_o = node_q;

endmodule
